// ===== design/phbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Property header blob parser: shared types and constants
// Parse phases, result event codes, the result record and the push bundle
// that the parse stage hands to the result queue.
// ----------------------------------------------------------------------------
package phbp_pkg;

  // Parse phase of the byte-level header state machine
  typedef enum logic [3:0] {
    PH_INFO    = 4'd0,
    PH_COUNT   = 4'd1,
    PH_SKIP    = 4'd2,
    PH_NAMELEN = 4'd3,
    PH_NAME    = 4'd4,
    PH_MIDX    = 4'd5,
    PH_MLEN    = 4'd6,
    PH_MDATA   = 4'd7
  } phase_e;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NAME = 2'd0,
    EV_META = 2'd1,
    EV_HDR  = 2'd2,
    EV_END  = 2'd3
  } event_e;

  // Compound properties carry no sample count
  localparam logic [1:0]  KindCompound = 2'd0;
  // Pool index value that escapes to an extra byte
  localparam logic [11:0] IdxEscape    = 12'hFFF;
  // Escape byte value that introduces inline metadata
  localparam logic [7:0]  InlineEscape = 8'hFF;

  // Result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned QLw    = $clog2(QDepth + 1);

  // One result item
  typedef struct packed {
    event_e      ev;
    logic [7:0]  byte_value;
    logic [1:0]  prop_kind;
    logic [3:0]  pod_type;
    logic [7:0]  extent;
    logic [31:0] sample_count;
    logic [7:0]  name_length;
    logic [11:0] md_index;
    logic        md_inline;
    logic [31:0] md_length;
    logic        blob_end;
    logic        run_last;
  } res_t;

  // Zero, one or two results produced by one accepted byte
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // Sample count width in bytes from the two-bit size code
  function automatic logic [3:0] count_width(input logic [1:0] code);
    logic [3:0] w;
    unique case (code)
      2'd0:    w = 4'd1;
      2'd1:    w = 4'd2;
      2'd2:    w = 4'd4;
      default: w = 4'd8;
    endcase
    return w;
  endfunction

endpackage

// ===== design/phbp_parse.sv =====
// ----------------------------------------------------------------------------
// Property header blob parser: parse stage
// Holds the header state registers and turns each accepted byte into up to
// two result items in the same cycle.
// ----------------------------------------------------------------------------
module phbp_parse
  import phbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       blob_last_i,
  output push_t      push_o
);

  typedef struct packed {
    phase_e      ph;
    logic [2:0]  fbi;
    logic [31:0] info;
    logic [31:0] cnt;
    logic [4:0]  skip;
    logic [7:0]  name_rem;
    logic [7:0]  name_len;
    logic [31:0] meta_rem;
    logic [31:0] meta_len;
  } st_t;

  st_t st_q, st_d;

  // Summary record for a completed header
  function automatic res_t mk_hdr(input st_t s, input logic [11:0] idx, input logic inl);
    res_t r;
    r           = '0;
    r.ev        = EV_HDR;
    r.prop_kind = s.info[1:0];
    if (s.info[1:0] != KindCompound) begin
      r.pod_type     = s.info[7:4];
      r.extent       = s.info[19:12];
      r.sample_count = s.cnt;
    end
    r.name_length = s.name_len;
    r.md_index    = inl ? 12'd0 : idx;
    r.md_inline   = inl;
    r.md_length   = inl ? s.meta_len : 32'd0;
    return r;
  endfunction

  // Next state and results for the byte at the input
  always_comb begin
    st_t        s;
    res_t       brow, hrow, r0, r1;
    logic       emit_b, emit_h;
    logic [1:0] n;
    logic [3:0] cw;
    logic [4:0] skip_sum;
    logic [2:0] fbi_nx;
    logic [4:0] sh;

    s        = st_q;
    brow     = '0;
    hrow     = '0;
    r0       = '0;
    r1       = '0;
    emit_b   = 1'b0;
    emit_h   = 1'b0;
    n        = 2'd0;
    cw       = count_width(st_q.info[3:2]);
    skip_sum = 5'd0;
    fbi_nx   = st_q.fbi + 3'd1;
    sh       = {st_q.fbi[1:0], 3'b000};

    unique case (st_q.ph)
      PH_COUNT: begin
        if (!st_q.fbi[2]) begin
          s.cnt = s.cnt | ({24'd0, data_byte_i} << sh);
        end
        s.fbi = fbi_nx;
        if (({1'b0, fbi_nx} >= cw) || (fbi_nx == 3'd0)) begin
          s.fbi    = 3'd0;
          skip_sum = (s.info[9] ? {cw, 1'b0} : 5'd0) + (s.info[8] ? 5'd4 : 5'd0);
          s.skip   = skip_sum;
          s.ph     = (skip_sum != 5'd0) ? PH_SKIP : PH_NAMELEN;
        end
      end
      PH_SKIP: begin
        s.skip = s.skip - 5'd1;
        if (s.skip == 5'd0) begin
          s.ph = PH_NAMELEN;
        end
      end
      PH_NAMELEN: begin
        s.name_len = data_byte_i;
        s.name_rem = data_byte_i;
        if (data_byte_i == 8'd0) begin
          // empty name: go straight to the metadata reference
          if (s.info[31:20] != IdxEscape) begin
            emit_h = 1'b1;
            hrow   = mk_hdr(s, s.info[31:20], 1'b0);
            s      = '0;
          end else begin
            s.ph = PH_MIDX;
          end
        end else begin
          s.ph = PH_NAME;
        end
      end
      PH_NAME: begin
        emit_b          = 1'b1;
        brow.ev         = EV_NAME;
        brow.byte_value = data_byte_i;
        s.name_rem      = s.name_rem - 8'd1;
        if (s.name_rem == 8'd0) begin
          if (s.info[31:20] != IdxEscape) begin
            emit_h = 1'b1;
            hrow   = mk_hdr(s, s.info[31:20], 1'b0);
            s      = '0;
          end else begin
            s.ph = PH_MIDX;
          end
        end
      end
      PH_MIDX: begin
        if (data_byte_i != InlineEscape) begin
          emit_h = 1'b1;
          hrow   = mk_hdr(s, {4'd0, data_byte_i}, 1'b0);
          s      = '0;
        end else begin
          s.meta_len = 32'd0;
          s.fbi      = 3'd0;
          s.ph       = PH_MLEN;
        end
      end
      PH_MLEN: begin
        s.meta_len = s.meta_len | ({24'd0, data_byte_i} << sh);
        s.fbi      = fbi_nx;
        if (fbi_nx[2]) begin
          s.fbi      = 3'd0;
          s.meta_rem = s.meta_len;
          if (s.meta_len == 32'd0) begin
            emit_h = 1'b1;
            hrow   = mk_hdr(s, 12'd0, 1'b1);
            s      = '0;
          end else begin
            s.ph = PH_MDATA;
          end
        end
      end
      PH_MDATA: begin
        emit_b          = 1'b1;
        brow.ev         = EV_META;
        brow.byte_value = data_byte_i;
        s.meta_rem      = s.meta_rem - 32'd1;
        if (s.meta_rem == 32'd0) begin
          emit_h = 1'b1;
          hrow   = mk_hdr(s, 12'd0, 1'b1);
          s      = '0;
        end
      end
      default: begin
        // info word collection; an unknown phase restarts here
        if (st_q.ph != PH_INFO) begin
          s      = '0;
          fbi_nx = 3'd1;
          sh     = 5'd0;
        end
        if (s.fbi == 3'd0) begin
          s.info = {24'd0, data_byte_i};
        end else begin
          s.info = s.info | ({24'd0, data_byte_i} << sh);
        end
        s.fbi = fbi_nx;
        if (fbi_nx[2]) begin
          s.fbi = 3'd0;
          if (s.info[1:0] == KindCompound) begin
            s.ph = PH_NAMELEN;
          end else begin
            s.cnt = 32'd0;
            s.ph  = PH_COUNT;
          end
        end
      end
    endcase

    // Blob end drops any partial header
    if (blob_last_i) begin
      s = '0;
    end

    // Order the results: byte first, then header summary, else blob end
    priority if (emit_b && emit_h) begin
      r0 = brow;
      r1 = hrow;
      n  = 2'd2;
    end else if (emit_b) begin
      r0 = brow;
      n  = 2'd1;
    end else if (emit_h) begin
      r0 = hrow;
      n  = 2'd1;
    end else if (blob_last_i) begin
      r0.ev = EV_END;
      n     = 2'd1;
    end else begin
      n = 2'd0;
    end

    r0.blob_end = blob_last_i;
    r1.blob_end = blob_last_i;
    if (n == 2'd2) begin
      r1.run_last = 1'b1;
    end else begin
      r0.run_last = 1'b1;
    end

    push_o.n  = accept_i ? n : 2'd0;
    push_o.r0 = r0;
    push_o.r1 = r1;
    st_d      = accept_i ? s : st_q;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// ===== design/phbp_queue.sv =====
// ----------------------------------------------------------------------------
// Property header blob parser: result queue
// Small queue that takes up to two results per cycle and hands out one
// per output transfer.
// ----------------------------------------------------------------------------
module phbp_queue
  import phbp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  push_t          push_i,
  input  logic           pop_i,
  output res_t           head_o,
  output logic           valid_o,
  output logic [QLw-1:0] level_o
);

  res_t           mem_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QLw-1:0] level_q, level_d;
  logic [QAw-1:0] wr_nx;
  logic           pop;

  assign pop   = pop_i && (level_q != '0);
  assign wr_nx = (wr_ptr_q == QAw'(QDepth - 1)) ? '0 : wr_ptr_q + QAw'(1);

  // Pointer and fill level update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    unique case (push_i.n)
      2'd1:    wr_ptr_d = wr_nx;
      2'd2:    wr_ptr_d = (wr_nx == QAw'(QDepth - 1)) ? '0 : wr_nx + QAw'(1);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QAw'(QDepth - 1)) ? '0 : rd_ptr_q + QAw'(1);
    end
    level_d = level_q + QLw'(push_i.n) - QLw'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_nx] <= push_i.r1;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (level_q != '0);
  assign level_o = level_q;

endmodule

// ===== design/property_header_blob_parser.sv =====
// ----------------------------------------------------------------------------
// Property header blob parser
// Byte-stream parser for packed property headers with name and inline
// metadata pass-through.
// ----------------------------------------------------------------------------
// Takes one blob byte per cycle on the slave stream (tlast marks the final
// byte) and emits results on the master stream: name bytes, inline metadata
// bytes, one summary per completed header, or a blob-end marker when the
// final byte produces nothing else. Each byte is parsed in the cycle it is
// transferred and its results go into a four-entry result queue; a byte
// yields up to two results and the output port drains one per cycle while
// the receiver is ready. With the output always ready, bytes are taken every
// cycle, though a byte producing two results (last name or metadata byte
// followed by the header summary) leaves the queue one result fuller; input
// stalls only when the queue holds more than two results. A header cut short
// by the blob end is dropped and parsing restarts at the next byte.
module property_header_blob_parser
  import phbp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic         s_axis_tlast_i,   // blob_last
  // master stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] byte_value, [9:8] prop_kind, [13:10] pod_type, [21:14] extent,
  // [53:22] sample_count, [61:54] name_length, [73:62] metadata_index,
  // [74] metadata_inline, [106:75] metadata_length, [111:107] zero
  output logic [111:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o,   // [1:0] event_res, [2] blob_end
  output logic         m_axis_tlast_o    // run_last
);

  push_t          push;
  res_t           head;
  logic [QLw-1:0] level;
  logic           in_xfer;

  // Room for two results before taking a byte
  assign s_axis_tready_o = (level <= QLw'(QDepth - 2));
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  phbp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_xfer),
    .data_byte_i (s_axis_tdata_i),
    .blob_last_i (s_axis_tlast_i),
    .push_o      (push)
  );

  phbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tready_i),
    .head_o  (head),
    .valid_o (m_axis_tvalid_o),
    .level_o (level)
  );

  // Output packing
  assign m_axis_tdata_o = {5'd0, head.md_length, head.md_inline, head.md_index,
                           head.name_length, head.sample_count, head.extent,
                           head.pod_type, head.prop_kind, head.byte_value};
  assign m_axis_tuser_o = {head.blob_end, head.ev};
  assign m_axis_tlast_o = head.run_last;

  // Checks
  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= QLw'(QDepth))
    else $error("result queue overfilled");

  a_last_has_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast_i) |-> (push.n != 2'd0))
    else $error("blob end byte produced no result");

  a_last_gives_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("no output after blob end byte");

  a_no_push_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |-> (push.n == 2'd0))
    else $error("results pushed without an input transfer");

endmodule

// ===== test/tb_property_header_blob_parser.sv =====
// ----------------------------------------------------------------------------
// Property header blob parser testbench
// Streams blobs of packed property headers into the byte port. The blobs are
// directed first, then random: well-formed headers with random content, cut
// headers and noise. The sender and the receiver idle at several rates, and
// one long receiver hold-off backs the block up. A local parser model
// predicts every result, and each result transfer is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_property_header_blob_parser;
  import phbp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Generous cycle budget for the slowest legal run
  localparam int unsigned RunLimit = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;

  // Traffic shaping
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  logic         hold_off = 1'b0;

  int unsigned  bytes_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;

  // Local header parser state
  phase_e       hp_phase;
  logic [2:0]   hp_pos;
  logic [31:0]  hp_info;
  logic [31:0]  hp_count;
  logic [4:0]   hp_skip;
  logic [7:0]   hp_name_left;
  logic [7:0]   hp_name_len;
  logic [31:0]  hp_meta_left;
  logic [31:0]  hp_meta_len;

  res_t         step_res[$];
  res_t         results_due[$];

  property_header_blob_parser dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Header parser model
  // ---------------------------------------------------------------------------

  function automatic void restart_parse();
    hp_phase     = PH_INFO;
    hp_pos       = '0;
    hp_info      = '0;
    hp_count     = '0;
    hp_skip      = '0;
    hp_name_left = '0;
    hp_name_len  = '0;
    hp_meta_left = '0;
    hp_meta_len  = '0;
  endfunction

  // Pass-through byte or blob-end marker
  function automatic void add_byte_result(event_e ev, logic [7:0] b);
    res_t r;
    r = '0;
    r.ev = ev;
    r.byte_value = b;
    step_res = {step_res, r};
  endfunction

  // Header summary; parsing starts over afterwards
  function automatic void add_header(logic [11:0] idx, logic inl);
    res_t r;
    r = '0;
    r.ev = EV_HDR;
    r.prop_kind = hp_info[1:0];
    if (hp_info[1:0] != KindCompound) begin
      r.pod_type     = hp_info[7:4];
      r.extent       = hp_info[19:12];
      r.sample_count = hp_count;
    end
    r.name_length = hp_name_len;
    r.md_index    = inl ? 12'd0 : idx;
    r.md_inline   = inl;
    r.md_length   = inl ? hp_meta_len : 32'd0;
    step_res = {step_res, r};
    restart_parse();
  endfunction

  // Pool index in the info word, or escape to an extra byte
  function automatic void name_done();
    if (hp_info[31:20] != IdxEscape) begin
      add_header(hp_info[31:20], 1'b0);
    end else begin
      hp_phase = PH_MIDX;
    end
  endfunction

  // Range and time-sampling bytes follow the count when flagged
  function automatic void count_done();
    logic [3:0] w;
    logic [4:0] s;
    w = 4'd1 << hp_info[3:2];
    s = '0;
    if (hp_info[9]) s = s + {w, 1'b0};
    if (hp_info[8]) s = s + 5'd4;
    hp_pos   = '0;
    hp_skip  = s;
    hp_phase = (s != 5'd0) ? PH_SKIP : PH_NAMELEN;
  endfunction

  // Results caused by one blob byte, appended to the due queue
  function automatic void parse_blob_byte(logic [7:0] b, logic last);
    logic [3:0] w;
    step_res.delete();
    case (hp_phase)
      PH_COUNT: begin
        w = 4'd1 << hp_info[3:2];
        // only the low four bytes of an eight-byte count are kept
        if (!hp_pos[2]) hp_count |= 32'(b) << {hp_pos[1:0], 3'b000};
        hp_pos = hp_pos + 3'd1;
        if ({1'b0, hp_pos} >= w || hp_pos == 3'd0) count_done();
      end
      PH_SKIP: begin
        hp_skip = hp_skip - 5'd1;
        if (hp_skip == 5'd0) hp_phase = PH_NAMELEN;
      end
      PH_NAMELEN: begin
        hp_name_len  = b;
        hp_name_left = b;
        if (b == 8'd0) begin
          name_done();
        end else begin
          hp_phase = PH_NAME;
        end
      end
      PH_NAME: begin
        add_byte_result(EV_NAME, b);
        hp_name_left = hp_name_left - 8'd1;
        if (hp_name_left == 8'd0) name_done();
      end
      PH_MIDX: begin
        if (b != InlineEscape) begin
          add_header({4'h0, b}, 1'b0);
        end else begin
          hp_meta_len = '0;
          hp_pos      = '0;
          hp_phase    = PH_MLEN;
        end
      end
      PH_MLEN: begin
        hp_meta_len |= 32'(b) << {hp_pos[1:0], 3'b000};
        hp_pos = hp_pos + 3'd1;
        if (hp_pos >= 3'd4) begin
          hp_pos       = '0;
          hp_meta_left = hp_meta_len;
          if (hp_meta_left == 32'd0) begin
            add_header(12'd0, 1'b1);
          end else begin
            hp_phase = PH_MDATA;
          end
        end
      end
      PH_MDATA: begin
        add_byte_result(EV_META, b);
        hp_meta_left = hp_meta_left - 32'd1;
        if (hp_meta_left == 32'd0) add_header(12'd0, 1'b1);
      end
      default: begin
        if (hp_pos == 3'd0) begin
          hp_info = 32'(b);
        end else begin
          hp_info |= 32'(b) << {hp_pos[1:0], 3'b000};
        end
        hp_pos = hp_pos + 3'd1;
        if (hp_pos >= 3'd4) begin
          hp_pos = '0;
          if (hp_info[1:0] == KindCompound) begin
            hp_phase = PH_NAMELEN;
          end else begin
            hp_count = '0;
            hp_phase = PH_COUNT;
          end
        end
      end
    endcase
    // blob end drops any partial header
    if (last) begin
      if (step_res.size() == 0) add_byte_result(EV_END, 8'h00);
      restart_parse();
    end
    foreach (step_res[k]) begin
      step_res[k].blob_end = last;
      step_res[k].run_last = (k == step_res.size() - 1);
      results_due = {results_due, step_res[k]};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("result %0d mismatch (expected/actual):%s", results_seen, msg);
  endfunction

  function automatic void check_result(res_t got);
    res_t  want;
    string diff;
    results_seen++;
    if (results_due.size() == 0) begin
      log_mismatch($sformatf(" none expected, got event %0d byte %02h", got.ev, got.byte_value));
      return;
    end
    want = results_due.pop_front();
    diff = "";
    if (got.ev !== want.ev)
      diff = {diff, $sformatf(" event %0d/%0d", want.ev, got.ev)};
    if (got.byte_value !== want.byte_value)
      diff = {diff, $sformatf(" byte %02h/%02h", want.byte_value, got.byte_value)};
    if (got.prop_kind !== want.prop_kind)
      diff = {diff, $sformatf(" kind %0d/%0d", want.prop_kind, got.prop_kind)};
    if (got.pod_type !== want.pod_type)
      diff = {diff, $sformatf(" pod %0d/%0d", want.pod_type, got.pod_type)};
    if (got.extent !== want.extent)
      diff = {diff, $sformatf(" extent %0d/%0d", want.extent, got.extent)};
    if (got.sample_count !== want.sample_count)
      diff = {diff, $sformatf(" count %08h/%08h", want.sample_count, got.sample_count)};
    if (got.name_length !== want.name_length)
      diff = {diff, $sformatf(" name_len %0d/%0d", want.name_length, got.name_length)};
    if (got.md_index !== want.md_index)
      diff = {diff, $sformatf(" md_index %03h/%03h", want.md_index, got.md_index)};
    if (got.md_inline !== want.md_inline)
      diff = {diff, $sformatf(" md_inline %0d/%0d", want.md_inline, got.md_inline)};
    if (got.md_length !== want.md_length)
      diff = {diff, $sformatf(" md_len %08h/%08h", want.md_length, got.md_length)};
    if (got.blob_end !== want.blob_end)
      diff = {diff, $sformatf(" blob_end %0d/%0d", want.blob_end, got.blob_end)};
    if (got.run_last !== want.run_last)
      diff = {diff, $sformatf(" run_last %0d/%0d", want.run_last, got.run_last)};
    if (diff != "") log_mismatch(diff);
  endfunction

  // Predict on input transfers, then check output transfers
  always @(posedge clk_i) begin
    res_t seen;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_o) parse_blob_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid_o && m_axis_tready) begin
        seen              = '0;
        seen.ev           = event_e'(m_axis_tuser_o[1:0]);
        seen.blob_end     = m_axis_tuser_o[2];
        seen.run_last     = m_axis_tlast_o;
        seen.byte_value   = m_axis_tdata_o[7:0];
        seen.prop_kind    = m_axis_tdata_o[9:8];
        seen.pod_type     = m_axis_tdata_o[13:10];
        seen.extent       = m_axis_tdata_o[21:14];
        seen.sample_count = m_axis_tdata_o[53:22];
        seen.name_length  = m_axis_tdata_o[61:54];
        seen.md_index     = m_axis_tdata_o[73:62];
        seen.md_inline    = m_axis_tdata_o[74];
        seen.md_length    = m_axis_tdata_o[106:75];
        check_result(seen);
      end
    end
  end

  // Receiver: random stalls plus the long hold-off
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RunLimit) begin
      $display("tb_property_header_blob_parser: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One byte transfer, after a random number of idle cycles
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_blob(input byte_q_t blob);
    foreach (blob[i]) send_byte(blob[i], i == blob.size() - 1);
  endtask

  // Blobs of one to three random headers; some cut short, some pure noise
  task automatic run_random_blobs(input int unsigned n_bytes);
    byte_q_t     blob;
    logic [31:0] info;
    int unsigned first, w, n_skip, n_name, md_mode, md_len, cut, i;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      blob.delete();
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) blob = {blob, 8'($urandom)};
      end else begin
        repeat ($urandom_range(1, 3)) begin
          info = $urandom;
          // 0: pool index in info, 1: escaped pool index, 2: inline string
          md_mode = $urandom_range(2);
          if (md_mode != 0) begin
            info[31:20] = IdxEscape;
          end else if (info[31:20] == IdxEscape) begin
            info[31:20] = 12'($urandom_range(12'hFFE));
          end
          for (i = 0; i < 4; i++) blob = {blob, info[8*i +: 8]};
          if (info[1:0] != KindCompound) begin
            w = 1 << info[3:2];
            n_skip = (info[9] ? 2 * w : 0) + (info[8] ? 4 : 0);
            repeat (w + n_skip) blob = {blob, 8'($urandom)};
          end
          n_name = ($urandom_range(39) == 0) ? $urandom_range(200, 255) : $urandom_range(8);
          blob = {blob, 8'(n_name)};
          repeat (n_name) blob = {blob, 8'($urandom)};
          if (md_mode == 1) begin
            blob = {blob, 8'($urandom_range(8'hFE))};
          end else if (md_mode == 2) begin
            md_len = ($urandom_range(49) == 0) ? $urandom_range(256, 300) : $urandom_range(6);
            blob = {blob, InlineEscape};
            for (i = 0; i < 4; i++) blob = {blob, 8'(md_len >> (8 * i))};
            repeat (md_len) blob = {blob, 8'($urandom)};
          end
        end
        // now and then the blob ends inside a header
        if ($urandom_range(5) == 0 && blob.size() > 1) begin
          cut = $urandom_range(1, blob.size() - 1);
          blob = blob[0:cut-1];
        end
      end
      send_blob(blob);
    end
  endtask

  // Compound header, eight-byte count, escapes, empty parts, partial header
  task automatic test_directed_headers();
    byte_q_t blob;
    send_idle_pct = 0;
    stall_pct     = 0;
    // compound, empty name, pool index 1, header done on the final byte
    blob = '{8'h00, 8'h00, 8'h10, 8'h00, 8'h00};
    send_blob(blob);
    // kind 3, eight-byte count, all-ones fields, one name byte, escaped pool
    // index; then a compound with empty inline metadata; then two bytes of a
    // header cut off by the blob end
    blob = '{8'hFF, 8'hF0, 8'hFF, 8'hFF,
             8'h78, 8'h56, 8'h34, 8'h12, 8'hAA, 8'hBB, 8'hCC, 8'hDD,
             8'h01, 8'hFF, 8'h00,
             8'h00, 8'h00, 8'hF0, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
             8'h5A, 8'hA5};
    send_blob(blob);
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random_blobs(360);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 87;
    stall_pct     = 0;
    run_random_blobs(360);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    stall_pct     = 87;
    run_random_blobs(360);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 34;
    stall_pct     = 34;
    run_random_blobs(360);
  endtask

  // Receiver held off while bytes keep coming, so the result queue fills
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      run_random_blobs(100);
    join
  endtask

  initial begin
    restart_parse();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_headers();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();

    // drain, then give the block time to show any extra results
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_property_header_blob_parser: done, clean");
    end else begin
      $display("tb_property_header_blob_parser: done, errors");
    end
    $finish;
  end

endmodule
